/* hw/rtl/hsl_to_rgb_converter_core_assert.svh */
// assertion macros for the hsl to rgb converter checker
// expects clk and rst_n in the scope that uses them
`ifndef HSL_TO_RGB_CONVERTER_CORE_ASSERT_SVH
`define HSL_TO_RGB_CONVERTER_CORE_ASSERT_SVH

// clocked check, off while reset is held
`define HSL2RGB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check, also live during reset
`define HSL2RGB_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hw/rtl/hsl2rgb_pkg.sv */
// package for the hsl to rgb converter: widths, constants, beat types, helpers
// no dependencies
`timescale 1ns / 1ps

package hsl2rgb_pkg;

  localparam int FRAC_BITS = 12;
  localparam int HUE_W     = FRAC_BITS;
  localparam int SL_W      = FRAC_BITS + 1;
  localparam int LS_W      = 2 * SL_W;
  localparam int Q_W       = 2 * FRAC_BITS + 1;
  localparam int W2        = 2 * FRAC_BITS + 2;
  localparam int T6_W      = FRAC_BITS + 3;
  localparam int NUM_W     = 3 * FRAC_BITS + 1;
  localparam int CH_W      = 8;
  localparam int NCH       = 3;
  localparam int STAGES    = 5;

  localparam logic [SL_W-1:0]  ONE      = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [SL_W-1:0]  HALF     = ONE >> 1;
  localparam logic [CH_W:0]    CH_MAX   = {1'b0, {CH_W{1'b1}}};
  localparam logic [T6_W-1:0]  T6_ONE   = T6_W'(ONE);
  localparam logic [T6_W-1:0]  T6_TWO   = T6_ONE << 1;
  localparam logic [T6_W-1:0]  T6_THREE = T6_ONE + T6_TWO;
  localparam logic [T6_W-1:0]  T6_FOUR  = T6_ONE << 2;
  localparam logic [T6_W-1:0]  T6_TURN  = T6_FOUR + T6_TWO;

  typedef struct packed {
    logic [HUE_W-1:0] hue;
    logic [SL_W-1:0]  saturation;
    logic [SL_W-1:0]  lightness;
  } hsl_pix_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } rgb_pix_t;

  function automatic logic [SL_W-1:0] clamp_one(input logic [SL_W-1:0] v);
    return (v > ONE) ? ONE : v;
  endfunction

  // hue position plus an offset, wrapped into one turn (six units of one)
  function automatic logic [T6_W-1:0] hue_wrap(input logic [T6_W-1:0] h6,
                                               input logic [T6_W-1:0] offs);
    logic [T6_W:0] sum;
    sum = {1'b0, h6} + {1'b0, offs};
    if (sum >= {1'b0, T6_TURN}) begin
      sum = sum - {1'b0, T6_TURN};
    end
    return sum[T6_W-1:0];
  endfunction

  // ramp weight between p and q, in units of 1/one
  function automatic logic [SL_W-1:0] ramp_frac(input logic [T6_W-1:0] t6);
    logic [T6_W-1:0] down;
    down = T6_FOUR - t6;
    if (t6 < T6_ONE) begin
      return t6[SL_W-1:0];
    end else if (t6 < T6_THREE) begin
      return ONE;
    end else if (t6 < T6_FOUR) begin
      return down[SL_W-1:0];
    end else begin
      return '0;
    end
  endfunction

  // floor(255 * num / one^3), saturated
  function automatic logic [CH_W-1:0] scale_ch(input logic [NUM_W-1:0] num);
    logic [NUM_W+CH_W-1:0] sc;
    logic [CH_W:0]         top;
    sc  = {num, {CH_W{1'b0}}} - {{CH_W{1'b0}}, num};
    top = sc[3*FRAC_BITS +: CH_W+1];
    return (top > CH_MAX) ? {CH_W{1'b1}} : top[CH_W-1:0];
  endfunction

endpackage

/* hw/rtl/hsl_to_rgb_converter_core.sv */
// hsl to rgb converter, five-stage pipeline, one pixel per clock unless stalled
// depends on hsl2rgb_pkg
`timescale 1ns / 1ps

// usage
//   in channel: one hsl pixel per beat (hue as fraction of a turn, saturation
//   and lightness in q12, values above 1.0 clamp to 1.0, hue wraps)
//   out channel: one rgb pixel per beat, 8 bits a channel
//   throughput: one pixel per cycle unless stalled; every one of the five
//     register stages can load in every cycle (clamp and l*s product, q/p and
//     ramp weights, span multiply, ramp sum, scale by 255)
//   each stage loads when it is empty or the stage after it moves, so
//   bubbles are squeezed out while the receiver stalls
//   receiver stall: out_data holds; in_ready drops only once every stage
//   holds a pixel
//   reset (rst_n low, synchronous): all stage valids clear, nothing in flight
//   is kept; in_ready is high in the cycle after reset ends
module hsl_to_rgb_converter_core (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  hsl2rgb_pkg::hsl_pix_t in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output hsl2rgb_pkg::rgb_pix_t out_data
);

  logic [hsl2rgb_pkg::STAGES-1:0] vld_r;
  logic [hsl2rgb_pkg::STAGES-1:0] vld_nxt;
  logic [hsl2rgb_pkg::STAGES-1:0] en;

  // stage 1
  logic [hsl2rgb_pkg::SL_W-1:0] s_r, s_nxt, l_r, l_nxt;
  logic [hsl2rgb_pkg::LS_W-1:0] ls_r, ls_nxt;
  logic [hsl2rgb_pkg::T6_W-1:0] h6;
  logic [hsl2rgb_pkg::T6_W-1:0] t6_r   [hsl2rgb_pkg::NCH];
  logic [hsl2rgb_pkg::T6_W-1:0] t6_nxt [hsl2rgb_pkg::NCH];
  // stage 2
  logic [hsl2rgb_pkg::W2-1:0]   lo_w, so_w, q_w, p_w, span_w;
  logic [hsl2rgb_pkg::Q_W-1:0]  p2_r, p2_nxt, span_r, span_nxt;
  logic [hsl2rgb_pkg::SL_W-1:0] frac_r   [hsl2rgb_pkg::NCH];
  logic [hsl2rgb_pkg::SL_W-1:0] frac_nxt [hsl2rgb_pkg::NCH];
  // stage 3
  logic [hsl2rgb_pkg::Q_W-1:0]  p3_r;
  logic [hsl2rgb_pkg::Q_W+hsl2rgb_pkg::SL_W-1:0] prod_full [hsl2rgb_pkg::NCH];
  logic [hsl2rgb_pkg::NUM_W-1:0] prod_r   [hsl2rgb_pkg::NCH];
  logic [hsl2rgb_pkg::NUM_W-1:0] prod_nxt [hsl2rgb_pkg::NCH];
  // stage 4
  logic [hsl2rgb_pkg::NUM_W-1:0] num_r   [hsl2rgb_pkg::NCH];
  logic [hsl2rgb_pkg::NUM_W-1:0] num_nxt [hsl2rgb_pkg::NCH];
  // stage 5
  hsl2rgb_pkg::rgb_pix_t out_r, out_nxt;

  // stage enables, back to front
  always_comb begin
    en[hsl2rgb_pkg::STAGES-1] = !vld_r[hsl2rgb_pkg::STAGES-1] || out_ready;
    for (int k = hsl2rgb_pkg::STAGES - 2; k >= 0; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
    vld_nxt[0] = en[0] ? in_valid : vld_r[0];
    for (int k = 1; k < hsl2rgb_pkg::STAGES; k++) begin
      vld_nxt[k] = en[k] ? vld_r[k-1] : vld_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_ready  = en[0];
  assign out_valid = vld_r[hsl2rgb_pkg::STAGES-1];
  assign out_data  = out_r;

  // stage 1: clamp, l*s, hue positions
  always_comb begin
    s_nxt  = hsl2rgb_pkg::clamp_one(in_data.saturation);
    l_nxt  = hsl2rgb_pkg::clamp_one(in_data.lightness);
    ls_nxt = s_nxt * l_nxt;
    h6     = hsl2rgb_pkg::T6_W'({in_data.hue, 2'b00})
           + hsl2rgb_pkg::T6_W'({in_data.hue, 1'b0});
    t6_nxt[0] = hsl2rgb_pkg::hue_wrap(h6, hsl2rgb_pkg::T6_TWO);
    t6_nxt[1] = h6;
    t6_nxt[2] = hsl2rgb_pkg::hue_wrap(h6, hsl2rgb_pkg::T6_FOUR);
  end

  // stage 2: q, p, span and ramp weights
  always_comb begin
    lo_w = hsl2rgb_pkg::W2'({l_r, {hsl2rgb_pkg::FRAC_BITS{1'b0}}});
    so_w = hsl2rgb_pkg::W2'({s_r, {hsl2rgb_pkg::FRAC_BITS{1'b0}}});
    if (l_r < hsl2rgb_pkg::HALF) begin
      q_w = lo_w + hsl2rgb_pkg::W2'(ls_r);
    end else begin
      q_w = lo_w + so_w - hsl2rgb_pkg::W2'(ls_r);
    end
    p_w      = (lo_w << 1) - q_w;
    span_w   = q_w - p_w;
    p2_nxt   = p_w[hsl2rgb_pkg::Q_W-1:0];
    span_nxt = span_w[hsl2rgb_pkg::Q_W-1:0];
    for (int c = 0; c < hsl2rgb_pkg::NCH; c++) begin
      frac_nxt[c] = hsl2rgb_pkg::ramp_frac(t6_r[c]);
    end
  end

  // stage 3: span times weight; stage 4: add p; stage 5: scale
  always_comb begin
    for (int c = 0; c < hsl2rgb_pkg::NCH; c++) begin
      prod_full[c] = span_r * frac_r[c];
      prod_nxt[c]  = prod_full[c][hsl2rgb_pkg::NUM_W-1:0];
      num_nxt[c]   = {p3_r, {hsl2rgb_pkg::FRAC_BITS{1'b0}}} + prod_r[c];
    end
    out_nxt.red   = hsl2rgb_pkg::scale_ch(num_r[0]);
    out_nxt.green = hsl2rgb_pkg::scale_ch(num_r[1]);
    out_nxt.blue  = hsl2rgb_pkg::scale_ch(num_r[2]);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s_r  <= s_nxt;
      l_r  <= l_nxt;
      ls_r <= ls_nxt;
      for (int c = 0; c < hsl2rgb_pkg::NCH; c++) begin
        t6_r[c] <= t6_nxt[c];
      end
    end
    if (en[1]) begin
      p2_r   <= p2_nxt;
      span_r <= span_nxt;
      for (int c = 0; c < hsl2rgb_pkg::NCH; c++) begin
        frac_r[c] <= frac_nxt[c];
      end
    end
    if (en[2]) begin
      p3_r <= p2_r;
      for (int c = 0; c < hsl2rgb_pkg::NCH; c++) begin
        prod_r[c] <= prod_nxt[c];
      end
    end
    if (en[3]) begin
      for (int c = 0; c < hsl2rgb_pkg::NCH; c++) begin
        num_r[c] <= num_nxt[c];
      end
    end
    if (en[4]) begin
      out_r <= out_nxt;
    end
  end

endmodule

/* hw/rtl/hsl2rgb_chk.sv */
// port checker for the hsl to rgb converter, bound to the top level
// depends on hsl2rgb_pkg and hsl_to_rgb_converter_core_assert.svh
`timescale 1ns / 1ps
`include "hsl_to_rgb_converter_core_assert.svh"

module hsl2rgb_chk (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_ready,
  input hsl2rgb_pkg::hsl_pix_t in_data,
  input logic                  out_valid,
  input logic                  out_ready,
  input hsl2rgb_pkg::rgb_pix_t out_data
);

  // a stalled result beat holds
  `HSL2RGB_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_data), "out beat changed while stalled")

  // a waiting input beat holds
  `HSL2RGB_ASSERT(a_in_hold, in_valid && !in_ready |=> in_valid && $stable(in_data), "in beat changed while waiting")

  // nothing survives reset
  `HSL2RGB_ASSERT_RST(a_rst_empty, !rst_n |=> !out_valid, "out_valid after reset")

  // a free-running receiver never backs up the input
  `HSL2RGB_ASSERT(a_ready_flow, out_ready |-> in_ready, "in_ready low while out_ready high")

  // input only blocks when the pipe is full and the receiver stalls
  `HSL2RGB_ASSERT(a_block_full, !in_ready |-> out_valid && !out_ready, "in_ready low without a stall")

endmodule

bind hsl_to_rgb_converter_core hsl2rgb_chk u_hsl2rgb_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
